// ===== src/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared codes, types and field layout of the berth schedule cost evaluator.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // item codes carried in s_tuser
  typedef enum logic [2:0] {
    OP_SERVICE = 3'd0,
    OP_SHIP    = 3'd1,
    OP_BERTH   = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_VISIT   = 3'd4,
    OP_EMPTY   = 3'd5
  } op_t;

  // what the back end has to do with an item
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_VISIT = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  first;
    logic  last;
  } bsc_ctrl_t;

  localparam int CTRL_W = $bits(bsc_ctrl_t);

  // input word layout
  localparam int BERTH_W     = 4;
  localparam int SHIP_W      = 6;
  localparam int VALUE_W     = 20;
  localparam int BERTH_LSB   = 0;
  localparam int SHIP_LSB    = BERTH_LSB + BERTH_W;
  localparam int VALUE_A_LSB = SHIP_LSB + SHIP_W;
  localparam int VALUE_B_LSB = VALUE_A_LSB + VALUE_W;
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 4;
  localparam int OP_W        = 3;
  localparam int FIRST_BIT   = 3;

  // output word layout
  localparam int COST_W      = 40;
  localparam int FINISH_W    = 20;
  localparam int OUT_TDATA_W = 64;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  // configuration port
  localparam int WEIGHT_W = 16;
  localparam int APB_W    = 32;
  localparam int PADDR_W  = 3;
  localparam logic REG_DEADLINE_WEIGHT = 1'b0;
  localparam logic REG_CLOSING_WEIGHT  = 1'b1;

endpackage

// ===== src/bsc_ram.sv =====
// ----------------------------------------------------------------------------
// bsc_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bsc_front.sv =====
// ----------------------------------------------------------------------------
// bsc_front
// Accepts input words, writes the tables, looks up the operands of visit
// and empty berth words, and hands classified items to the queue.
// ----------------------------------------------------------------------------
module bsc_front #(
  parameter int MAX_SHIPS  = 64,
  parameter int MAX_BERTHS = 16,
  parameter int TIME_BITS  = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bsc_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic [bsc_pkg::IN_TUSER_W-1:0] s_tuser,
  input  logic                           s_tlast,
  output logic                           q_push,
  input  logic                           q_full,
  output bsc_pkg::bsc_ctrl_t             q_ctrl,
  output logic [TIME_BITS-1:0]           q_svc,
  output logic [TIME_BITS-1:0]           q_arr,
  output logic [TIME_BITS-1:0]           q_dl,
  output logic [TIME_BITS-1:0]           q_open,
  output logic [TIME_BITS-1:0]           q_close
);

  import bsc_pkg::*;

  localparam int BIW     = MAX_BERTHS > 1 ? $clog2(MAX_BERTHS) : 1;
  localparam int SIW     = MAX_SHIPS > 1 ? $clog2(MAX_SHIPS) : 1;
  localparam int SVC_D   = MAX_BERTHS * MAX_SHIPS;
  localparam int SAW     = SVC_D > 1 ? $clog2(SVC_D) : 1;
  localparam int VW      = TIME_BITS > VALUE_W ? TIME_BITS : VALUE_W;
  localparam int BERTH_N = 1 << BERTH_W;
  localparam int SHIP_N  = 1 << SHIP_W;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  // index wrap tables
  logic [BIW-1:0] berth_tab [BERTH_N];
  logic [SIW-1:0] ship_tab  [SHIP_N];

  for (genvar g = 0; g < BERTH_N; g++) begin : g_bwrap
    localparam int BV = g % MAX_BERTHS;
    assign berth_tab[g] = BIW'(BV);
  end

  for (genvar g = 0; g < SHIP_N; g++) begin : g_swrap
    localparam int SV = g % MAX_SHIPS;
    assign ship_tab[g] = SIW'(SV);
  end

  logic                 acc;
  op_t                  op;
  logic [BIW-1:0]       b_idx;
  logic [SIW-1:0]       s_idx;
  logic [VW-1:0]        va_ext;
  logic [VW-1:0]        vb_ext;
  logic [TIME_BITS-1:0] va;
  logic [TIME_BITS-1:0] vb;
  logic [SAW-1:0]       svc_addr;
  logic                 svc_we;
  logic                 ship_we;
  logic                 berth_we;
  logic                 svc_re;
  logic                 berth_re;
  bsc_ctrl_t            ctrl_in;
  logic                 s1_valid;
  bsc_ctrl_t            s1_ctrl;

  assign s_tready = !s1_valid || !q_full;
  assign acc      = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser[OP_W-1:0]);
  assign b_idx    = berth_tab[s_tdata[BERTH_LSB +: BERTH_W]];
  assign s_idx    = ship_tab[s_tdata[SHIP_LSB +: SHIP_W]];

  // values above the time range are stored clamped
  assign va_ext = VW'(s_tdata[VALUE_A_LSB +: VALUE_W]);
  assign vb_ext = VW'(s_tdata[VALUE_B_LSB +: VALUE_W]);
  assign va     = (va_ext > VW'(TMAX)) ? TMAX : va_ext[TIME_BITS-1:0];
  assign vb     = (vb_ext > VW'(TMAX)) ? TMAX : vb_ext[TIME_BITS-1:0];

  assign svc_addr = SAW'(b_idx) * SAW'(MAX_SHIPS) + SAW'(s_idx);

  assign svc_we   = acc && (op == OP_SERVICE);
  assign ship_we  = acc && (op == OP_SHIP);
  assign berth_we = acc && (op == OP_BERTH);
  assign svc_re   = acc && (op == OP_VISIT);
  assign berth_re = acc && ((op == OP_VISIT) || (op == OP_EMPTY));

  always_comb begin
    ctrl_in.first = s_tuser[FIRST_BIT];
    ctrl_in.last  = s_tlast;
    unique case (op)
      OP_CLEAR: ctrl_in.kind = KIND_CLEAR;
      OP_VISIT: ctrl_in.kind = KIND_VISIT;
      OP_EMPTY: ctrl_in.kind = KIND_EMPTY;
      default:  ctrl_in.kind = KIND_NONE;
    endcase
  end

  bsc_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (SVC_D)
  ) u_svc_ram (
    .clk   (clk),
    .we    (svc_we),
    .waddr (svc_addr),
    .wdata (va),
    .re    (svc_re),
    .raddr (svc_addr),
    .rdata (q_svc)
  );

  // ship entry: deadline above arrival
  bsc_ram #(
    .WIDTH (2 * TIME_BITS),
    .DEPTH (MAX_SHIPS)
  ) u_ship_ram (
    .clk   (clk),
    .we    (ship_we),
    .waddr (s_idx),
    .wdata ({vb, va}),
    .re    (svc_re),
    .raddr (s_idx),
    .rdata ({q_dl, q_arr})
  );

  // berth entry: closing above opening
  bsc_ram #(
    .WIDTH (2 * TIME_BITS),
    .DEPTH (MAX_BERTHS)
  ) u_berth_ram (
    .clk   (clk),
    .we    (berth_we),
    .waddr (b_idx),
    .wdata ({vb, va}),
    .re    (berth_re),
    .raddr (b_idx),
    .rdata ({q_close, q_open})
  );

  // read data stays put while the word waits here, since the next read
  // only happens when this word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctrl <= ctrl_in;
    end
  end

  assign q_push = s1_valid && !q_full;
  assign q_ctrl = s1_ctrl;

endmodule

// ===== src/bsc_fifo.sv =====
// ----------------------------------------------------------------------------
// bsc_fifo
// Short register queue between the lookup front end and the cost back end.
// ----------------------------------------------------------------------------
module bsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      priority if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/bsc_back.sv =====
// ----------------------------------------------------------------------------
// bsc_back
// Five-stage cost pipeline: running time, penalty distances, weighting,
// per-item sum and the saturating cost accumulator, which is the output word.
// ----------------------------------------------------------------------------
module bsc_back #(
  parameter int TIME_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [bsc_pkg::WEIGHT_W-1:0]    deadline_weight,
  input  logic [bsc_pkg::WEIGHT_W-1:0]    closing_weight,
  input  logic                            h_valid,
  input  bsc_pkg::bsc_ctrl_t              h_ctrl,
  input  logic [TIME_BITS-1:0]            h_svc,
  input  logic [TIME_BITS-1:0]            h_arr,
  input  logic [TIME_BITS-1:0]            h_dl,
  input  logic [TIME_BITS-1:0]            h_open,
  input  logic [TIME_BITS-1:0]            h_close,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bsc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  import bsc_pkg::*;

  localparam int TB   = TIME_BITS;
  localparam int PW   = WEIGHT_W + TB;
  localparam int SUMW = PW + 2;
  localparam int AW   = (SUMW > COST_W ? SUMW : COST_W) + 1;
  localparam logic [TB-1:0] TMAX = '1;

  logic en;

  // running time loop
  logic [TB-1:0] rt_state;
  logic          tsat_state;
  logic [TB-1:0] base;
  logic [TB-1:0] start;
  logic [TB:0]   sum;
  logic [TB-1:0] rt_vis;
  logic [TB-1:0] rt_n;
  logic          tsat_n;

  // stage registers
  logic          v1, v2, v3, v4, v5;
  bsc_ctrl_t     c1;
  kind_t         k2, k3, k4;
  logic [TB-1:0] rt1, rt2, rt3, rt4;
  logic          ts1, ts2, ts3, ts4;
  logic [TB-1:0] arr1, dl1, cl1;
  logic [TB-1:0] darr2, ddl2, dcl2;
  logic [TB-1:0] darr3;
  logic [PW-1:0] pdl3, pcl3;
  logic [SUMW-1:0] part4;

  logic [TB-1:0] darr_n, ddl_n, dcl_n;
  logic          closes;

  // accumulator and output word
  logic [COST_W-1:0]   cost;
  logic                csat;
  logic [AW-1:0]       csum;
  logic [COST_W-1:0]   cost_next;
  logic                csat_next;
  logic [FINISH_W-1:0] finish5;
  logic                sat5;
  logic [31:0]         rt4_ext;

  assign en       = !v5 || m_tready;
  assign pop      = en && h_valid;
  assign m_tvalid = v5;

  // stage 1: time update
  assign base   = h_ctrl.first ? h_open : rt_state;
  assign start  = (base < h_arr) ? h_arr : base;
  assign sum    = (TB + 1)'(start) + (TB + 1)'(h_svc);
  assign rt_vis = sum[TB] ? TMAX : sum[TB-1:0];

  always_comb begin
    unique case (h_ctrl.kind)
      KIND_CLEAR: begin
        rt_n   = '0;
        tsat_n = 1'b0;
      end
      KIND_VISIT: begin
        rt_n   = rt_vis;
        tsat_n = tsat_state | sum[TB];
      end
      KIND_EMPTY: begin
        rt_n   = h_open;
        tsat_n = tsat_state;
      end
      KIND_NONE: begin
        rt_n   = rt_state;
        tsat_n = tsat_state;
      end
    endcase
  end

  // stage 2: distances past arrival, deadline and closing
  assign closes = ((c1.kind == KIND_VISIT) && c1.last) || (c1.kind == KIND_EMPTY);
  assign darr_n = (c1.kind == KIND_VISIT) ? rt1 - arr1 : '0;
  assign ddl_n  = ((c1.kind == KIND_VISIT) && (rt1 > dl1)) ? rt1 - dl1 : '0;
  assign dcl_n  = (closes && (rt1 > cl1)) ? rt1 - cl1 : '0;

  // stage 5: saturating accumulate
  assign csum    = AW'(cost) + AW'(part4);
  assign rt4_ext = 32'(rt4);

  always_comb begin
    cost_next = cost;
    csat_next = csat;
    if (k4 == KIND_CLEAR) begin
      cost_next = '0;
      csat_next = 1'b0;
    end else if (csum > AW'(COST_MAX)) begin
      cost_next = COST_MAX;
      csat_next = 1'b1;
    end else begin
      cost_next = csum[COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_state   <= '0;
      tsat_state <= 1'b0;
      cost       <= '0;
      csat       <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      v5         <= 1'b0;
    end else if (en) begin
      if (h_valid) begin
        rt_state   <= rt_n;
        tsat_state <= tsat_n;
      end
      if (v4) begin
        cost <= cost_next;
        csat <= csat_next;
      end
      v1 <= h_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1    <= h_ctrl;
      rt1   <= rt_n;
      ts1   <= tsat_n;
      arr1  <= h_arr;
      dl1   <= h_dl;
      cl1   <= h_close;

      k2    <= c1.kind;
      rt2   <= rt1;
      ts2   <= ts1;
      darr2 <= darr_n;
      ddl2  <= ddl_n;
      dcl2  <= dcl_n;

      k3    <= k2;
      rt3   <= rt2;
      ts3   <= ts2;
      darr3 <= darr2;
      pdl3  <= PW'(deadline_weight) * PW'(ddl2);
      pcl3  <= PW'(closing_weight) * PW'(dcl2);

      k4    <= k3;
      rt4   <= rt3;
      ts4   <= ts3;
      part4 <= SUMW'(darr3) + SUMW'(pdl3) + SUMW'(pcl3);

      finish5 <= rt4_ext[FINISH_W-1:0];
      sat5    <= csat_next | ts4;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - COST_W - FINISH_W - 1)'(0), sat5, finish5, cost};

endmodule

// ===== src/berth_schedule_cost.sv =====
// ----------------------------------------------------------------------------
// berth_schedule_cost
// Streaming cost evaluator for a berth allocation schedule.
// ----------------------------------------------------------------------------
// Every input word gives exactly one output word, in order. Words are taken
// one per clock cycle while the output side does not stall. The front end
// writes the service, ship and berth tables and reads the operands of visits
// from them in a single registered RAM access, a four-entry queue decouples
// it from the back end, and the back end closes its two feedback loops
// (running time in its first stage, cost accumulator in its last) each
// within a single stage, which sets the one-word-per-cycle rate. The
// multipliers for the deadline and closing weights sit in a stage of their
// own. Tables come out of reset undefined and must be loaded before they are
// read; no clearing pass runs. The user must write weights over the register
// port only while no words are in flight; the block does not enforce it.
module berth_schedule_cost #(
  parameter int MAX_SHIPS  = 64,
  parameter int MAX_BERTHS = 16,
  parameter int TIME_BITS  = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // berth [3:0], ship [9:4], value_a [29:10], value_b [49:30], zero fill
  input  logic [bsc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // op [2:0], first_visit [3]
  input  logic [bsc_pkg::IN_TUSER_W-1:0]  s_tuser,
  // last_visit
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // total_cost [39:0], finish_time [59:40], saturated [60], zero fill
  output logic [bsc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsc_pkg::PADDR_W-1:0]     paddr,
  input  logic [bsc_pkg::APB_W-1:0]       pwdata,
  output logic [bsc_pkg::APB_W-1:0]       prdata,
  output logic                            pready
);

  import bsc_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QW     = CTRL_W + 5 * TIME_BITS;

  logic [WEIGHT_W-1:0] deadline_weight;
  logic [WEIGHT_W-1:0] closing_weight;
  logic                cfg_wr;

  logic                 q_push;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  bsc_ctrl_t            f_ctrl;
  logic [TIME_BITS-1:0] f_svc, f_arr, f_dl, f_open, f_close;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  bsc_ctrl_t            h_ctrl;
  logic [TIME_BITS-1:0] h_svc, h_arr, h_dl, h_open, h_close;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline_weight <= WEIGHT_W'(1);
      closing_weight  <= WEIGHT_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DEADLINE_WEIGHT: deadline_weight <= pwdata[WEIGHT_W-1:0];
        REG_CLOSING_WEIGHT:  closing_weight  <= pwdata[WEIGHT_W-1:0];
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_CLOSING_WEIGHT) ? APB_W'(closing_weight)
                                                   : APB_W'(deadline_weight);

  bsc_front #(
    .MAX_SHIPS  (MAX_SHIPS),
    .MAX_BERTHS (MAX_BERTHS),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_ctrl   (f_ctrl),
    .q_svc    (f_svc),
    .q_arr    (f_arr),
    .q_dl     (f_dl),
    .q_open   (f_open),
    .q_close  (f_close)
  );

  assign q_wdata = {f_ctrl, f_svc, f_arr, f_dl, f_open, f_close};

  bsc_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  assign {h_ctrl, h_svc, h_arr, h_dl, h_open, h_close} = q_rdata;

  bsc_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .deadline_weight (deadline_weight),
    .closing_weight  (closing_weight),
    .h_valid         (!q_empty),
    .h_ctrl          (h_ctrl),
    .h_svc           (h_svc),
    .h_arr           (h_arr),
    .h_dl            (h_dl),
    .h_open          (h_open),
    .h_close         (h_close),
    .pop             (q_pop),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

endmodule

// ===== src/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the berth schedule cost evaluator, bound to the top.
// ----------------------------------------------------------------------------
module bsc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bsc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // reset empties the pipeline
  a_rst_no_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // reset empties the front stage, so the input side opens at once
  a_rst_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input side not ready right after reset");

endmodule

bind berth_schedule_cost bsc_checker u_bsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/berth_schedule_cost_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// berth_schedule_cost_tb
// Self-checking bench for the berth schedule cost evaluator. A short table of
// directed words covers the table extremes, every op, time and cost
// saturation and clears. It is followed by phases of random schedule runs
// and stray words under several weight settings. Every output word is checked
// against a cycle-free predictor, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module berth_schedule_cost_tb;
  import bsc_pkg::*;

  localparam real CLK_PERIOD     = 8.0;
  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  PHASE_WORDS    = 84;
  localparam int  PHASES         = 6;

  localparam logic [OP_W-1:0]    OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0]    OP_SPARE_7 = 3'd7;
  localparam logic [VALUE_W-1:0] TIME_TOP   = '1;
  localparam logic [PADDR_W-1:0] ADDR_DEADLINE_WEIGHT = PADDR_W'({REG_DEADLINE_WEIGHT, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_CLOSING_WEIGHT  = PADDR_W'({REG_CLOSING_WEIGHT, 2'b00});

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [BERTH_W-1:0] berth;
    logic [SHIP_W-1:0]  ship;
    logic [VALUE_W-1:0] value_a;
    logic [VALUE_W-1:0] value_b;
    logic               first;
    logic               last;
  } sched_word_t;

  typedef struct packed {
    logic [COST_W-1:0]   cost;
    logic [FINISH_W-1:0] finish;
    logic                sat;
  } cost_word_t;

  typedef struct {
    bit                  set_weights;
    logic [WEIGHT_W-1:0] dw;
    logic [WEIGHT_W-1:0] cw;
    sched_word_t         w;
    bit                  pinned;
    cost_word_t          r;
  } plan_row_t;

  logic                   clk     = 1'b0;
  logic                   rst     = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_W-1:0]     paddr   = '0;
  logic [APB_W-1:0]       pwdata  = '0;
  logic [APB_W-1:0]       prdata;
  logic                   pready;

  berth_schedule_cost DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // predictor state
  logic [VALUE_W-1:0]  svc_time    [0:1023];
  logic [VALUE_W-1:0]  ship_arr    [0:63];
  logic [VALUE_W-1:0]  ship_due    [0:63];
  logic [VALUE_W-1:0]  berth_open  [0:15];
  logic [VALUE_W-1:0]  berth_close [0:15];
  bit                  svc_known   [0:1023];
  bit                  ship_known  [0:63];
  bit                  berth_known [0:15];
  logic [VALUE_W-1:0]  quay_time = '0;
  logic [COST_W-1:0]   cost_sum = '0;
  logic                sat_seen = 1'b0;
  logic [WEIGHT_W-1:0] due_weight = 16'd1;
  logic [WEIGHT_W-1:0] close_weight = 16'd1;

  cost_word_t pending_costs[$];
  plan_row_t  plan[$];

  bit calm = 1'b0;
  int mismatches = 0;
  int words_sent = 0;
  int visits_sent = 0;
  int empties_sent = 0;
  int results_checked = 0;
  int sat_results = 0;
  int weight_writes = 0;
  int stall_cycles = 0;
  cost_word_t got_word, want_word;

  function automatic sched_word_t mk(logic [OP_W-1:0] op, logic [BERTH_W-1:0] b,
                                     logic [SHIP_W-1:0] s, logic [VALUE_W-1:0] va,
                                     logic [VALUE_W-1:0] vb, logic f, logic l);
    sched_word_t w;
    w = '{op: op, berth: b, ship: s, value_a: va, value_b: vb, first: f, last: l};
    return w;
  endfunction

  function automatic plan_row_t word_row(sched_word_t w, bit pinned = 1'b0,
                                         cost_word_t r = '0);
    plan_row_t row;
    row = '{set_weights: 1'b0, dw: '0, cw: '0, w: w, pinned: pinned, r: r};
    return row;
  endfunction

  function automatic plan_row_t weight_row(logic [WEIGHT_W-1:0] dw, logic [WEIGHT_W-1:0] cw);
    plan_row_t row;
    row = '{set_weights: 1'b1, dw: dw, cw: cw, w: '0, pinned: 1'b0, r: '0};
    return row;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_time();
    case ($urandom_range(4))
      0: return '0;
      1: return TIME_TOP;
      2: return VALUE_W'($urandom_range(255));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic void charge(logic [63:0] amount);
    logic [63:0] sum;
    sum = 64'(cost_sum) + amount;
    if (amount > 64'(COST_MAX) || sum > 64'(COST_MAX)) begin
      sat_seen = 1'b1;
      cost_sum = COST_MAX;
    end else begin
      cost_sum = sum[COST_W-1:0];
    end
  endfunction

  function automatic void charge_overrun(logic [BERTH_W-1:0] b);
    if (quay_time > berth_close[b])
      charge(64'(close_weight) * 64'(quay_time - berth_close[b]));
  endfunction

  // advances the schedule state by one word and returns the cost word it gives
  function automatic cost_word_t advance_schedule(sched_word_t w);
    logic [VALUE_W-1:0] arrival;
    logic [VALUE_W:0]   done;
    logic [9:0]         pair;
    pair = {w.berth, w.ship};
    case (w.op)
      OP_SERVICE: begin
        svc_time[pair] = w.value_a;
        svc_known[pair] = 1'b1;
      end
      OP_SHIP: begin
        ship_arr[w.ship] = w.value_a;
        ship_due[w.ship] = w.value_b;
        ship_known[w.ship] = 1'b1;
      end
      OP_BERTH: begin
        berth_open[w.berth] = w.value_a;
        berth_close[w.berth] = w.value_b;
        berth_known[w.berth] = 1'b1;
      end
      OP_CLEAR: begin
        cost_sum = '0;
        quay_time = '0;
        sat_seen = 1'b0;
      end
      OP_VISIT: begin
        arrival = ship_arr[w.ship];
        if (w.first) quay_time = berth_open[w.berth];
        if (quay_time < arrival) quay_time = arrival;
        done = {1'b0, quay_time} + {1'b0, svc_time[pair]};
        if (done > {1'b0, TIME_TOP}) begin
          sat_seen = 1'b1;
          quay_time = TIME_TOP;
        end else begin
          quay_time = done[VALUE_W-1:0];
        end
        charge(64'(quay_time - arrival));
        if (quay_time > ship_due[w.ship])
          charge(64'(due_weight) * 64'(quay_time - ship_due[w.ship]));
        if (w.last) charge_overrun(w.berth);
      end
      OP_EMPTY: begin
        quay_time = berth_open[w.berth];
        charge_overrun(w.berth);
      end
      default: ;
    endcase
    return '{cost: cost_sum, finish: quay_time, sat: sat_seen};
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
  endfunction

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(sched_word_t w, bit pinned = 1'b0, cost_word_t r = '0);
    cost_word_t want;
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({w.value_b, w.value_a, w.ship, w.berth});
    s_tuser  <= {w.first, w.op};
    s_tlast  <= w.last;
    do @(posedge clk); while (!s_tready);
    want = advance_schedule(w);
    pending_costs.push_back(pinned ? r : want);
    words_sent++;
    if (w.op == OP_VISIT) visits_sent++;
    if (w.op == OP_EMPTY) empties_sent++;
    @(negedge clk);
  endtask

  // wait until every word in flight has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_costs.size() != 0) @(negedge clk);
  endtask

  // leaves the bus selected; the caller releases it after the last access
  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [WEIGHT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_W'(value);
    @(negedge clk) penable <= 1'b1;
    // read the register back
    @(negedge clk) begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_W'(value))
      note_mismatch($sformatf("register %0d read %h, wrote %h", addr, prdata, value));
    @(negedge clk);
  endtask

  task automatic write_weights(logic [WEIGHT_W-1:0] dw, logic [WEIGHT_W-1:0] cw);
    reg_write(ADDR_DEADLINE_WEIGHT, dw);
    due_weight = dw;
    reg_write(ADDR_CLOSING_WEIGHT, cw);
    close_weight = cw;
    psel    <= 1'b0;
    penable <= 1'b0;
    weight_writes += 2;
  endtask

  // loads what a berth needs, then streams its ships in order, or an empty berth if none
  task automatic schedule_run();
    logic [BERTH_W-1:0] b;
    logic [SHIP_W-1:0]  s;
    logic [SHIP_W-1:0]  ships[6];
    int n;
    b = BERTH_W'($urandom);
    n = $urandom_range(6);
    if (!berth_known[b] || $urandom_range(3) == 0)
      send_word(mk(OP_BERTH, b, SHIP_W'($urandom), pick_time(), pick_time(), 1'($urandom),
                   1'($urandom)));
    for (int i = 0; i < n; i++) begin
      s = SHIP_W'($urandom);
      ships[i] = s;
      if (!ship_known[s] || $urandom_range(3) == 0)
        send_word(mk(OP_SHIP, BERTH_W'($urandom), s, pick_time(), pick_time(), 1'($urandom),
                     1'($urandom)));
      if (!svc_known[{b, s}] || $urandom_range(3) == 0)
        send_word(mk(OP_SERVICE, b, s, pick_time(), VALUE_W'($urandom), 1'($urandom),
                     1'($urandom)));
    end
    if ($urandom_range(2) == 0)
      send_word(mk(OP_CLEAR, BERTH_W'($urandom), SHIP_W'($urandom), VALUE_W'($urandom),
                   VALUE_W'($urandom), 1'($urandom), 1'($urandom)));
    if (n == 0)
      send_word(mk(OP_EMPTY, b, SHIP_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom),
                   1'($urandom), 1'($urandom)));
    for (int i = 0; i < n; i++)
      send_word(mk(OP_VISIT, b, ships[i], VALUE_W'($urandom), VALUE_W'($urandom),
                   i == 0, i == n - 1));
  endtask

  // any op with random fields; a read of an unloaded entry becomes that load
  task automatic stray_word();
    sched_word_t w;
    w = mk(OP_W'($urandom_range(7)), BERTH_W'($urandom), SHIP_W'($urandom), pick_time(),
           pick_time(), 1'($urandom), 1'($urandom));
    if (w.op == OP_VISIT) begin
      if (!svc_known[{w.berth, w.ship}]) w.op = OP_SERVICE;
      else if (!ship_known[w.ship]) w.op = OP_SHIP;
      else if ((w.first || w.last) && !berth_known[w.berth]) w.op = OP_BERTH;
    end else if (w.op == OP_EMPTY && !berth_known[w.berth]) begin
      w.op = OP_BERTH;
    end
    send_word(w);
  endtask

  always @(negedge clk) m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word = '{cost: m_tdata[39:0], finish: m_tdata[59:40], sat: m_tdata[60]};
      results_checked++;
      if (got_word.sat) sat_results++;
      if (pending_costs.size() == 0) begin
        note_mismatch($sformatf("unexpected word cost %h finish %h sat %b",
                                got_word.cost, got_word.finish, got_word.sat));
      end else begin
        want_word = pending_costs.pop_front();
        if (got_word.cost !== want_word.cost || got_word.finish !== want_word.finish ||
            got_word.sat !== want_word.sat)
          note_mismatch($sformatf("cost %h/%h finish %h/%h sat %b/%b (want/got)",
                                  want_word.cost, got_word.cost, want_word.finish,
                                  got_word.finish, want_word.sat, got_word.sat));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("berth_schedule_cost regression: fail");
      $finish;
    end
  end

  initial begin
    logic [WEIGHT_W-1:0] dw, cw;
    int phase_start;

    // directed part, default weights of one
    plan.push_back(word_row(mk(OP_SPARE_6, 4'd5, 6'd9, TIME_TOP, TIME_TOP, 1, 1), 1, '0));
    plan.push_back(word_row(mk(OP_BERTH, 4'd15, 6'd0, 20'd0, TIME_TOP, 0, 0), 1, '0));
    plan.push_back(word_row(mk(OP_BERTH, 4'd0, 6'd63, 20'd100, 20'd200, 1, 0), 1, '0));
    plan.push_back(word_row(mk(OP_SHIP, 4'd15, 6'd63, TIME_TOP, TIME_TOP, 0, 1), 1, '0));
    plan.push_back(word_row(mk(OP_SHIP, 4'd0, 6'd0, 20'd50, 20'd150, 0, 0), 1, '0));
    plan.push_back(word_row(mk(OP_SERVICE, 4'd0, 6'd0, 20'd30, 20'd0, 0, 0), 1, '0));
    plan.push_back(word_row(mk(OP_SERVICE, 4'd15, 6'd63, TIME_TOP, TIME_TOP, 1, 1), 1, '0));
    // running time from opening, then carried on, then past the deadline
    plan.push_back(word_row(mk(OP_VISIT, 4'd0, 6'd0, 20'd0, 20'd0, 1, 0)));
    plan.push_back(word_row(mk(OP_VISIT, 4'd0, 6'd0, 20'd0, 20'd0, 0, 1)));
    plan.push_back(word_row(mk(OP_EMPTY, 4'd0, 6'd0, 20'd0, 20'd0, 0, 0)));
    // time clamps at its top
    plan.push_back(word_row(mk(OP_VISIT, 4'd15, 6'd63, 20'd0, 20'd0, 1, 1)));
    plan.push_back(word_row(mk(OP_SPARE_7, 4'd0, 6'd0, 20'd0, 20'd0, 0, 0)));
    plan.push_back(word_row(mk(OP_CLEAR, 4'd15, 6'd63, TIME_TOP, TIME_TOP, 1, 1), 1, '0));
    plan.push_back(word_row(mk(OP_EMPTY, 4'd15, 6'd0, 20'd0, 20'd0, 0, 0)));
    // cost runs into its ceiling with both weights at their top
    plan.push_back(weight_row('1, '1));
    plan.push_back(word_row(mk(OP_CLEAR, 4'd0, 6'd0, 20'd0, 20'd0, 0, 0), 1, '0));
    plan.push_back(word_row(mk(OP_BERTH, 4'd1, 6'd0, 20'd0, 20'd0, 0, 0)));
    plan.push_back(word_row(mk(OP_SHIP, 4'd0, 6'd1, 20'd0, 20'd0, 0, 0)));
    plan.push_back(word_row(mk(OP_SERVICE, 4'd1, 6'd1, TIME_TOP, 20'd0, 0, 0)));
    for (int i = 0; i < 9; i++)
      plan.push_back(word_row(mk(OP_VISIT, 4'd1, 6'd1, 20'd0, 20'd0, 1, 1)));

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].set_weights) begin
        settle();
        write_weights(plan[i].dw, plan[i].cw);
      end else begin
        send_word(plan[i].w, plan[i].pinned, plan[i].r);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin dw = '0; cw = '0; end
        1: begin dw = '1; cw = '1; end
        3: begin dw = 16'd1; cw = '1; end
        5: begin dw = '1; cw = '0; end
        default: begin
          dw = WEIGHT_W'($urandom);
          cw = WEIGHT_W'($urandom);
        end
      endcase
      write_weights(dw, cw);
      // one phase runs with both sides always ready
      calm = (p == 3);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        if ($urandom_range(99) < 75) schedule_run();
        else stray_word();
      end
    end

    settle();
    calm = 1'b0;
    repeat (16) @(negedge clk);
    if (pending_costs.size() != 0)
      note_mismatch($sformatf("%0d words never came out", pending_costs.size()));

    $display("sent %0d words (%0d visits, %0d empty berths), checked %0d results",
             words_sent, visits_sent, empties_sent, results_checked);
    $display("%0d weight writes, %0d saturated results, %0d mismatches",
             weight_writes, sat_results, mismatches);
    if (mismatches == 0) begin
      $display("berth_schedule_cost regression: pass");
    end else begin
      $display("berth_schedule_cost regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bsc_pkg.sv
src/bsc_ram.sv
src/bsc_front.sv
src/bsc_fifo.sv
src/bsc_back.sv
src/berth_schedule_cost.sv
src/bsc_checker.sv
bench/berth_schedule_cost_tb.sv
